// ===== sv/csmm_pkg.sv =====
// Shared widths, types and constants for the carry-save Montgomery multiplier.
// Used by csmm_ctrl, csmm_dp and carry_save_montgomery_multiplier; no dependencies.
package csmm_pkg;

	localparam int OPERAND_BITS = 14;
	// Running value stays below b + M < 2^(N+1): two guard bits are enough.
	localparam int ACC_BITS     = OPERAND_BITS + 2;
	localparam int CNT_BITS     = $clog2(OPERAND_BITS);

	typedef logic [OPERAND_BITS-1:0] operand_t;
	typedef logic [ACC_BITS-1:0]     acc_t;
	typedef logic [ACC_BITS:0]       ext_t;
	typedef logic [CNT_BITS-1:0]     cnt_t;

	localparam operand_t MODULUS_RESET = operand_t'(7);
	localparam cnt_t     LAST_STEP     = cnt_t'(OPERAND_BITS - 1);

	// Controller to datapath commands.
	typedef struct packed {
		logic load;     // capture operands, clear sum and carry
		logic step;     // one carry-save add / reduce / halve step
		logic fin_add;  // resolve sum + carry into one vector
		logic reduce;   // conditional subtract into the output register
	} csmm_cmd_t;

endpackage

// ===== sv/csmm_dp.sv =====
// Datapath of the carry-save Montgomery multiplier: operand, sum/carry,
// total, output and modulus registers. Depends on csmm_pkg.
module csmm_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  csmm_pkg::csmm_cmd_t cmd,
	input  logic                cfg_we,
	input  csmm_pkg::operand_t  cfg_modulus,
	input  csmm_pkg::operand_t  a_in,
	input  csmm_pkg::operand_t  b_in,
	output csmm_pkg::operand_t  product_out
);

	csmm_pkg::operand_t modulus_q;
	csmm_pkg::operand_t a_q;
	csmm_pkg::operand_t b_q;
	csmm_pkg::acc_t     sum_q;
	csmm_pkg::acc_t     carry_q;
	csmm_pkg::acc_t     total_q;
	csmm_pkg::operand_t product_q;

	csmm_pkg::ext_t x, y, b_sel, m_sel, s1, c1, c1x2, s2, c2;
	csmm_pkg::acc_t m_ext, diff;

	always_comb begin
		x     = csmm_pkg::ext_t'(sum_q);
		y     = csmm_pkg::ext_t'(carry_q);
		b_sel = a_q[0] ? csmm_pkg::ext_t'(b_q) : '0;
		// first carry-save layer: S + b
		s1    = x ^ y ^ b_sel;
		c1    = (x & y) | (x & b_sel) | (y & b_sel);
		c1x2  = {c1[csmm_pkg::ACC_BITS-1:0], 1'b0};
		// parity of S + b is the low sum bit, carry vector is even
		m_sel = s1[0] ? csmm_pkg::ext_t'(modulus_q) : '0;
		// second layer: add modulus when odd
		s2    = s1 ^ c1x2 ^ m_sel;
		c2    = (s1 & c1x2) | (s1 & m_sel) | (c1x2 & m_sel);
		m_ext = csmm_pkg::acc_t'(modulus_q);
		diff  = (total_q >= m_ext) ? (total_q - m_ext) : total_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= csmm_pkg::MODULUS_RESET;
		end else if (cfg_we) begin
			modulus_q <= cfg_modulus;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q     <= a_in;
			b_q     <= b_in;
			sum_q   <= '0;
			carry_q <= '0;
		end else if (cmd.step) begin
			a_q     <= a_q >> 1;
			// halve: s2 is even, c2 already carries weight one half
			sum_q   <= csmm_pkg::acc_t'(s2 >> 1);
			carry_q <= csmm_pkg::acc_t'(c2);
		end
		if (cmd.fin_add) begin
			total_q <= sum_q + carry_q;
		end
		if (cmd.reduce) begin
			product_q <= csmm_pkg::operand_t'(diff);
		end
	end

	assign product_out = product_q;

endmodule

// ===== sv/csmm_ctrl.sv =====
// Sequencer of the carry-save Montgomery multiplier: step counter, state
// machine and output valid. Depends on csmm_pkg.
module csmm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output csmm_pkg::csmm_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_FINAL,
		ST_REDUCE
	} state_t;

	state_t         state_q;
	csmm_pkg::cnt_t cnt_q;
	logic           out_valid_q;
	logic           can_load_out;
	logic           accept;

	assign can_load_out = !out_valid_q || out_ready;
	assign in_ready     = (state_q == ST_IDLE) || (state_q == ST_REDUCE && can_load_out);
	assign accept       = in_valid && in_ready;
	assign out_valid    = out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.load    = accept;
		cmd.step    = (state_q == ST_STEP);
		cmd.fin_add = (state_q == ST_FINAL);
		cmd.reduce  = (state_q == ST_REDUCE) && can_load_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// drop valid once taken, raise on a new result
			if (cmd.reduce) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_STEP;
						cnt_q   <= '0;
					end
				end
				ST_STEP: begin
					if (cnt_q == csmm_pkg::LAST_STEP) begin
						state_q <= ST_FINAL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FINAL: begin
					state_q <= ST_REDUCE;
				end
				ST_REDUCE: begin
					if (can_load_out) begin
						if (accept) begin
							state_q <= ST_STEP;
							cnt_q   <= '0;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/carry_save_montgomery_multiplier.sv =====
// Top level of the radix-2 carry-save Montgomery multiplier.
// Instantiates csmm_ctrl and csmm_dp; depends on csmm_pkg.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------
//   cfg      | cfg_valid / cfg_ready  | modulus
//   in       | in_valid  / in_ready   | a_operand, b_operand
//   out      | out_valid / out_ready  | product
//
// An item runs one carry-save add/reduce/halve step per operand bit, then one
// carry-propagate add and one conditional subtract.
// A new item is taken in the cycle the previous result moves to the output
// register, so back-to-back items need no idle state between them.
// Reset clears control and sets the modulus to 7. A stalled output holds the
// finished value in the subtract stage until the output register frees up.
// Write the modulus only while no item is in flight.
module carry_save_montgomery_multiplier (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [csmm_pkg::OPERAND_BITS-1:0] modulus,
	// input items
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [csmm_pkg::OPERAND_BITS-1:0] a_operand,
	input  logic [csmm_pkg::OPERAND_BITS-1:0] b_operand,
	// result items
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [csmm_pkg::OPERAND_BITS-1:0] product
);

	csmm_pkg::csmm_cmd_t cmd;

	// Configuration writes are always accepted.
	assign cfg_ready = 1'b1;

	// Sequence the step count and the output handshake.
	csmm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Hold operands, the sum/carry pair, and the modulus.
	csmm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_valid),
		.cfg_modulus (modulus),
		.a_in        (a_operand),
		.b_in        (b_operand),
		.product_out (product)
	);

endmodule
